FILE: rtl/assert_macros.svh
// Assertion helpers shared by the deque RTL.
// The asserting module must have clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// When the first expression holds, the second holds in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/dld_pkg.sv
`default_nettype none

package dld_pkg;

    localparam int NODE_COUNT = 256;
    localparam int DATA_W     = 32;
    localparam int SEL_W      = 8;
    localparam int IDX_W      = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int PTR_W      = IDX_W + 1;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [PTR_W-1:0]  ptr_t;
    typedef logic [DATA_W-1:0] data_t;
    typedef logic [SEL_W-1:0]  sel_t;
    typedef logic [2:0]        req_t;
    typedef logic [1:0]        status_t;

    // The null link is one past the last node.
    localparam ptr_t NIL = PTR_W'(NODE_COUNT);

    localparam req_t REQ_PUSH_BACK  = 3'd0;
    localparam req_t REQ_PUSH_FRONT = 3'd1;
    localparam req_t REQ_POP_BACK   = 3'd2;
    localparam req_t REQ_POP_FRONT  = 3'd3;
    localparam req_t REQ_UNLINK     = 3'd4;
    localparam req_t REQ_RELINK     = 3'd5;

    localparam status_t STATUS_DONE  = 2'd0;
    localparam status_t STATUS_FULL  = 2'd1;
    localparam status_t STATUS_EMPTY = 2'd2;

    // Link memory port: one registered read and one write per cycle.
    typedef struct packed {
        logic rd_en;
        idx_t rd_addr;
        logic wr_en;
        idx_t wr_addr;
        ptr_t wr_data;
    } lnk_port_t;

    typedef struct packed {
        logic  rd_en;
        idx_t  rd_addr;
        logic  wr_en;
        idx_t  wr_addr;
        data_t wr_data;
    } pay_port_t;

    typedef struct packed {
        logic rd_en;
        idx_t rd_addr;
        logic wr_en;
        idx_t wr_addr;
        idx_t wr_data;
    } fre_port_t;

    typedef struct packed {
        status_t status;
        sel_t    node_index;
        data_t   front_value;
        data_t   back_value;
        logic    is_empty;
    } res_t;

    // Any link value at or above the node count means no node.
    function automatic logic is_node(input ptr_t p);
        return p < NIL;
    endfunction

    function automatic ptr_t norm_ptr(input ptr_t p);
        return is_node(p) ? p : NIL;
    endfunction

    function automatic logic sel_in_range(input sel_t s);
        return int'(s) < NODE_COUNT;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/dld_ram.sv
`default_nettype none

module dld_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: rtl/dld_ctrl.sv
`default_nettype none
`include "assert_macros.svh"

module dld_ctrl
    import dld_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire req_t      req_type,
    input  wire data_t     payload,
    input  wire sel_t      node_sel,
    output logic           res_valid,
    input  wire logic      res_ready,
    output res_t           res,
    output pay_port_t      pay_port,
    input  wire data_t     pay_rd_data,
    output lnk_port_t      prv_port,
    input  wire ptr_t      prv_rd_data,
    output lnk_port_t      nxt_port,
    input  wire ptr_t      nxt_rd_data,
    output fre_port_t      fre_port,
    input  wire idx_t      fre_rd_data
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_PUSH_A = 3'd1;
    localparam logic [2:0] ST_PUSH_B = 3'd2;
    localparam logic [2:0] ST_LINK   = 3'd3;
    localparam logic [2:0] ST_FETCH  = 3'd4;
    localparam logic [2:0] ST_DONE   = 3'd5;

    logic [2:0] state_reg, state_next;
    ptr_t       head_reg, head_next;
    ptr_t       tail_reg, tail_next;
    ptr_t       fresh_reg, fresh_next;
    ptr_t       free_top_reg, free_top_next;
    logic       use_stack_reg, use_stack_next;
    logic       fetch_head_reg, fetch_head_next;

    req_t       req_reg, req_next;
    data_t      data_reg, data_next;
    ptr_t       node_reg, node_next;
    status_t    status_reg, status_next;
    sel_t       idx_out_reg, idx_out_next;
    data_t      head_val_reg, head_val_next;
    data_t      tail_val_reg, tail_val_next;

    ptr_t       free_dec;
    ptr_t       push_node;
    ptr_t       p_lnk;
    ptr_t       q_lnk;
    logic       p_ok;
    logic       q_ok;
    logic       accept;

    assign accept    = in_valid && in_ready;
    assign free_dec  = free_top_reg - PTR_W'(1);
    // A recycled node arrives from the free stack read issued at accept.
    assign push_node = use_stack_reg ? PTR_W'(fre_rd_data) : node_reg;
    assign p_lnk     = prv_rd_data;
    assign q_lnk     = nxt_rd_data;
    assign p_ok      = is_node(p_lnk);
    assign q_ok      = is_node(q_lnk);

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        fresh_next      = fresh_reg;
        free_top_next   = free_top_reg;
        use_stack_next  = use_stack_reg;
        fetch_head_next = fetch_head_reg;
        req_next        = req_reg;
        data_next       = data_reg;
        node_next       = node_reg;
        status_next     = status_reg;
        idx_out_next    = idx_out_reg;
        head_val_next   = head_val_reg;
        tail_val_next   = tail_val_reg;
        pay_port        = '0;
        prv_port        = '0;
        nxt_port        = '0;
        fre_port        = '0;
        in_ready        = 1'b0;
        res_valid       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (accept)
                begin
                    req_next       = req_type;
                    data_next      = payload;
                    status_next    = STATUS_DONE;
                    idx_out_next   = '0;
                    use_stack_next = 1'b0;
                    state_next     = ST_DONE;
                    case (req_type)
                        REQ_PUSH_BACK, REQ_PUSH_FRONT:
                        begin
                            if (free_top_reg != '0)
                            begin
                                fre_port.rd_en   = 1'b1;
                                fre_port.rd_addr = free_dec[IDX_W-1:0];
                                free_top_next    = free_dec;
                                use_stack_next   = 1'b1;
                                state_next       = ST_PUSH_A;
                            end
                            else if (is_node(fresh_reg))
                            begin
                                node_next  = fresh_reg;
                                fresh_next = fresh_reg + PTR_W'(1);
                                state_next = ST_PUSH_A;
                            end
                            else
                            begin
                                status_next = STATUS_FULL;
                            end
                        end
                        REQ_POP_BACK, REQ_POP_FRONT:
                        begin
                            node_next = (req_type == REQ_POP_BACK) ? tail_reg : head_reg;
                            if (!is_node(node_next))
                            begin
                                status_next = STATUS_EMPTY;
                            end
                            else
                            begin
                                idx_out_next     = SEL_W'(node_next);
                                prv_port.rd_en   = 1'b1;
                                prv_port.rd_addr = node_next[IDX_W-1:0];
                                nxt_port.rd_en   = 1'b1;
                                nxt_port.rd_addr = node_next[IDX_W-1:0];
                                // Return the node to the free stack unless it is full.
                                if (free_top_reg < NIL)
                                begin
                                    fre_port.wr_en   = 1'b1;
                                    fre_port.wr_addr = free_top_reg[IDX_W-1:0];
                                    fre_port.wr_data = node_next[IDX_W-1:0];
                                    free_top_next    = free_top_reg + PTR_W'(1);
                                end
                                state_next = ST_LINK;
                            end
                        end
                        REQ_UNLINK, REQ_RELINK:
                        begin
                            idx_out_next = node_sel;
                            if (sel_in_range(node_sel))
                            begin
                                node_next        = PTR_W'(node_sel);
                                prv_port.rd_en   = 1'b1;
                                prv_port.rd_addr = node_next[IDX_W-1:0];
                                nxt_port.rd_en   = 1'b1;
                                nxt_port.rd_addr = node_next[IDX_W-1:0];
                                pay_port.rd_en   = 1'b1;
                                pay_port.rd_addr = node_next[IDX_W-1:0];
                                state_next       = ST_LINK;
                            end
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_PUSH_A:
            begin
                node_next        = push_node;
                use_stack_next   = 1'b0;
                idx_out_next     = SEL_W'(push_node);
                pay_port.wr_en   = 1'b1;
                pay_port.wr_addr = push_node[IDX_W-1:0];
                pay_port.wr_data = data_reg;
                // Keep the end caches equal to the payload of the end nodes.
                if (push_node == head_reg)
                begin
                    head_val_next = data_reg;
                end
                if (push_node == tail_reg)
                begin
                    tail_val_next = data_reg;
                end
                prv_port.wr_en   = 1'b1;
                prv_port.wr_addr = push_node[IDX_W-1:0];
                prv_port.wr_data = NIL;
                nxt_port.wr_en   = 1'b1;
                nxt_port.wr_addr = push_node[IDX_W-1:0];
                nxt_port.wr_data = NIL;
                if (!is_node(head_reg))
                begin
                    head_next     = push_node;
                    tail_next     = push_node;
                    head_val_next = data_reg;
                    tail_val_next = data_reg;
                    state_next    = ST_DONE;
                end
                else if (req_reg == REQ_PUSH_BACK)
                begin
                    prv_port.wr_data = norm_ptr(tail_reg);
                    state_next       = ST_PUSH_B;
                end
                else
                begin
                    nxt_port.wr_data = head_reg;
                    state_next       = ST_PUSH_B;
                end
            end

            ST_PUSH_B:
            begin
                if (req_reg == REQ_PUSH_BACK)
                begin
                    if (is_node(tail_reg))
                    begin
                        nxt_port.wr_en   = 1'b1;
                        nxt_port.wr_addr = tail_reg[IDX_W-1:0];
                        nxt_port.wr_data = node_reg;
                    end
                    tail_next     = node_reg;
                    tail_val_next = data_reg;
                end
                else
                begin
                    prv_port.wr_en   = 1'b1;
                    prv_port.wr_addr = head_reg[IDX_W-1:0];
                    prv_port.wr_data = node_reg;
                    head_next        = node_reg;
                    head_val_next    = data_reg;
                end
                state_next = ST_DONE;
            end

            ST_LINK:
            begin
                state_next = ST_DONE;
                case (req_reg)
                    REQ_POP_BACK:
                    begin
                        if (p_ok)
                        begin
                            nxt_port.wr_en   = 1'b1;
                            nxt_port.wr_addr = p_lnk[IDX_W-1:0];
                            nxt_port.wr_data = NIL;
                            tail_next        = p_lnk;
                            pay_port.rd_en   = 1'b1;
                            pay_port.rd_addr = p_lnk[IDX_W-1:0];
                            fetch_head_next  = 1'b0;
                            state_next       = ST_FETCH;
                        end
                        else
                        begin
                            head_next = NIL;
                            tail_next = NIL;
                        end
                    end
                    REQ_POP_FRONT:
                    begin
                        if (q_ok)
                        begin
                            prv_port.wr_en   = 1'b1;
                            prv_port.wr_addr = q_lnk[IDX_W-1:0];
                            prv_port.wr_data = NIL;
                            head_next        = q_lnk;
                            pay_port.rd_en   = 1'b1;
                            pay_port.rd_addr = q_lnk[IDX_W-1:0];
                            fetch_head_next  = 1'b1;
                            state_next       = ST_FETCH;
                        end
                        else
                        begin
                            head_next = NIL;
                            tail_next = NIL;
                        end
                    end
                    REQ_UNLINK:
                    begin
                        if (p_ok)
                        begin
                            nxt_port.wr_en   = 1'b1;
                            nxt_port.wr_addr = p_lnk[IDX_W-1:0];
                            nxt_port.wr_data = q_lnk;
                        end
                        else
                        begin
                            head_next = norm_ptr(q_lnk);
                        end
                        if (q_ok)
                        begin
                            prv_port.wr_en   = 1'b1;
                            prv_port.wr_addr = q_lnk[IDX_W-1:0];
                            prv_port.wr_data = p_lnk;
                        end
                        else
                        begin
                            tail_next = norm_ptr(p_lnk);
                        end
                        // At most one end moves onto a node whose payload is not cached.
                        if (!p_ok && q_ok)
                        begin
                            pay_port.rd_en   = 1'b1;
                            pay_port.rd_addr = q_lnk[IDX_W-1:0];
                            fetch_head_next  = 1'b1;
                            state_next       = ST_FETCH;
                        end
                        else if (p_ok && !q_ok)
                        begin
                            pay_port.rd_en   = 1'b1;
                            pay_port.rd_addr = p_lnk[IDX_W-1:0];
                            fetch_head_next  = 1'b0;
                            state_next       = ST_FETCH;
                        end
                    end
                    REQ_RELINK:
                    begin
                        if (p_ok)
                        begin
                            nxt_port.wr_en   = 1'b1;
                            nxt_port.wr_addr = p_lnk[IDX_W-1:0];
                            nxt_port.wr_data = node_reg;
                        end
                        else
                        begin
                            head_next     = node_reg;
                            head_val_next = pay_rd_data;
                        end
                        if (q_ok)
                        begin
                            prv_port.wr_en   = 1'b1;
                            prv_port.wr_addr = q_lnk[IDX_W-1:0];
                            prv_port.wr_data = node_reg;
                        end
                        else
                        begin
                            tail_next     = node_reg;
                            tail_val_next = pay_rd_data;
                        end
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end

            ST_FETCH:
            begin
                if (fetch_head_reg)
                begin
                    head_val_next = pay_rd_data;
                end
                else
                begin
                    tail_val_next = pay_rd_data;
                end
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            head_reg       <= NIL;
            tail_reg       <= NIL;
            fresh_reg      <= '0;
            free_top_reg   <= '0;
            use_stack_reg  <= 1'b0;
            fetch_head_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            fresh_reg      <= fresh_next;
            free_top_reg   <= free_top_next;
            use_stack_reg  <= use_stack_next;
            fetch_head_reg <= fetch_head_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        data_reg     <= data_next;
        node_reg     <= node_next;
        status_reg   <= status_next;
        idx_out_reg  <= idx_out_next;
        head_val_reg <= head_val_next;
        tail_val_reg <= tail_val_next;
    end

    assign res.status      = status_reg;
    assign res.node_index  = idx_out_reg;
    assign res.front_value = is_node(head_reg) ? head_val_reg : '0;
    assign res.back_value  = is_node(tail_reg) ? tail_val_reg : '0;
    assign res.is_empty    = !is_node(head_reg);

    `ASSERT_ALWAYS(a_free_top_range, free_top_reg <= NIL, "free stack count past node count")
    `ASSERT_ALWAYS(a_fresh_range, fresh_reg <= NIL, "fresh count past node count")
    `ASSERT_NEXT(a_accept_leaves_idle, accept, state_reg != ST_IDLE, "accepted word not started")
    `ASSERT_NEXT(a_result_holds, res_valid && !res_ready, res_valid && $stable(res), "result lost")

endmodule

`default_nettype wire

FILE: rtl/linked_deque_with_unlink_restore.sv
`default_nettype none

// Channel   Direction  Handshake              Fields
// request   in         in_valid / in_ready    req_type, payload, node_sel
// result    out        out_valid / out_ready  status, node_index, front_value,
//                                             back_value, is_empty
//
// One request word is worked at a time. A failed request goes straight from
// acceptance to the result; a push writes the node and then the neighbor
// link, and a pop or unlink reads the node links, writes the neighbors and
// then reads the new end payload. The read-then-write walk through the
// registered link memories sets these steps.
// Reset clears the end pointers and the allocation counters at once; the
// node memories need no clearing pass.
// The result register decouples the two sides, so a new request is taken
// while the previous result still waits for out_ready.

module linked_deque_with_unlink_restore
    import dld_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire req_t    req_type,
    input  wire data_t   payload,
    input  wire sel_t    node_sel,
    output logic         out_valid,
    input  wire logic    out_ready,
    output status_t      status,
    output sel_t         node_index,
    output data_t        front_value,
    output data_t        back_value,
    output logic         is_empty
);

    pay_port_t pay_port;
    lnk_port_t prv_port;
    lnk_port_t nxt_port;
    fre_port_t fre_port;
    data_t     pay_rd_data;
    ptr_t      prv_rd_data;
    ptr_t      nxt_rd_data;
    idx_t      fre_rd_data;

    logic      res_valid;
    logic      res_ready;
    res_t      res;

    logic      out_valid_reg, out_valid_next;
    res_t      out_reg;

    // Node payloads, both link directions and the stack of freed nodes each
    // sit in a memory of their own.
    dld_ram #(.WIDTH(DATA_W), .DEPTH(NODE_COUNT)) u_pay_ram (
        .clk     (clk),
        .wr_en   (pay_port.wr_en),
        .wr_addr (pay_port.wr_addr),
        .wr_data (pay_port.wr_data),
        .rd_en   (pay_port.rd_en),
        .rd_addr (pay_port.rd_addr),
        .rd_data (pay_rd_data)
    );

    dld_ram #(.WIDTH(PTR_W), .DEPTH(NODE_COUNT)) u_prv_ram (
        .clk     (clk),
        .wr_en   (prv_port.wr_en),
        .wr_addr (prv_port.wr_addr),
        .wr_data (prv_port.wr_data),
        .rd_en   (prv_port.rd_en),
        .rd_addr (prv_port.rd_addr),
        .rd_data (prv_rd_data)
    );

    dld_ram #(.WIDTH(PTR_W), .DEPTH(NODE_COUNT)) u_nxt_ram (
        .clk     (clk),
        .wr_en   (nxt_port.wr_en),
        .wr_addr (nxt_port.wr_addr),
        .wr_data (nxt_port.wr_data),
        .rd_en   (nxt_port.rd_en),
        .rd_addr (nxt_port.rd_addr),
        .rd_data (nxt_rd_data)
    );

    dld_ram #(.WIDTH(IDX_W), .DEPTH(NODE_COUNT)) u_fre_ram (
        .clk     (clk),
        .wr_en   (fre_port.wr_en),
        .wr_addr (fre_port.wr_addr),
        .wr_data (fre_port.wr_data),
        .rd_en   (fre_port.rd_en),
        .rd_addr (fre_port.rd_addr),
        .rd_data (fre_rd_data)
    );

    dld_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .payload     (payload),
        .node_sel    (node_sel),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .pay_port    (pay_port),
        .pay_rd_data (pay_rd_data),
        .prv_port    (prv_port),
        .prv_rd_data (prv_rd_data),
        .nxt_port    (nxt_port),
        .nxt_rd_data (nxt_rd_data),
        .fre_port    (fre_port),
        .fre_rd_data (fre_rd_data)
    );

    // The result register takes a new word when it is empty or being drained.
    assign res_ready      = !out_valid_reg || out_ready;
    assign out_valid_next = (res_valid && res_ready) || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_reg.status;
    assign node_index  = out_reg.node_index;
    assign front_value = out_reg.front_value;
    assign back_value  = out_reg.back_value;
    assign is_empty    = out_reg.is_empty;

endmodule

`default_nettype wire
